// ----- rtl/ole_pkg.sv -----
`default_nettype none
package ole_pkg;

  localparam int DEPTH_DEF = 64;

  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_RM_FRONT  = 3'd2;
  localparam logic [2:0] CMD_RM_BACK   = 3'd3;
  localparam logic [2:0] CMD_FIND      = 3'd4;
  localparam logic [2:0] CMD_RM_MATCH  = 3'd5;
  localparam logic [2:0] CMD_MOVE      = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_FIRST     = 3'd4;

  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_CLR       = 4'd1;
  localparam logic [3:0] OP_START     = 4'd2;
  localparam logic [3:0] OP_INS       = 4'd3;
  localparam logic [3:0] OP_RMF       = 4'd4;
  localparam logic [3:0] OP_RMB_FIRST = 4'd5;
  localparam logic [3:0] OP_RMB_STEP  = 4'd6;
  localparam logic [3:0] OP_RMB_END   = 4'd7;
  localparam logic [3:0] OP_SSTEP     = 4'd8;
  localparam logic [3:0] OP_MATCH     = 4'd9;
  localparam logic [3:0] OP_FIN2      = 4'd10;
  localparam logic [3:0] OP_MISS      = 4'd11;
  localparam logic [3:0] OP_LOAD      = 4'd12;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] st;
  } ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [2:0] cmd;
    logic       match;
    logic       srch_last;
    logic       rmb_last;
    logic       at_first;
    logic       clr_last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/ole_ctrl.sv -----
`default_nettype none
module ole_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic [2:0]   in_command,
  input  wire ole_pkg::sts_t sts,
  output logic              in_stall,
  output ole_pkg::ctl_t     ctl
);
  import ole_pkg::*;

  localparam logic [3:0] S_CLR       = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_INS       = 4'd2;
  localparam logic [3:0] S_RMF       = 4'd3;
  localparam logic [3:0] S_RMB_FIRST = 4'd4;
  localparam logic [3:0] S_RMB_WALK  = 4'd5;
  localparam logic [3:0] S_SRCH      = 4'd6;
  localparam logic [3:0] S_FIN2      = 4'd7;
  localparam logic [3:0] S_RESP      = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl.op    = OP_NONE;
    ctl.st    = ST_OK;
    case (state_r)
      S_CLR: begin
        ctl.op = OP_CLR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.op = OP_START;
          case (in_command)
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (sts.full) begin
                ctl.st = ST_FULL;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_INS;
              end
            end
            CMD_RM_FRONT: begin
              if (sts.empty) begin
                ctl.st = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_RMF;
              end
            end
            CMD_RM_BACK: begin
              if (sts.empty) begin
                ctl.st = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_RMB_FIRST;
              end
            end
            CMD_FIND, CMD_RM_MATCH, CMD_MOVE: begin
              if (sts.empty) begin
                ctl.st = ST_NOT_FOUND;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_INS: begin
        ctl.op = OP_INS;
        state_nxt = S_RESP;
      end
      S_RMF: begin
        ctl.op = OP_RMF;
        state_nxt = S_RESP;
      end
      S_RMB_FIRST: begin
        ctl.op = OP_RMB_FIRST;
        state_nxt = S_RMB_WALK;
      end
      S_RMB_WALK: begin
        if (sts.rmb_last) begin
          ctl.op = OP_RMB_END;
          state_nxt = S_RESP;
        end else begin
          ctl.op = OP_RMB_STEP;
        end
      end
      S_SRCH: begin
        if (sts.match) begin
          ctl.op = OP_MATCH;
          if (sts.cmd == CMD_FIND || (sts.cmd == CMD_MOVE && sts.at_first)) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_FIN2;
          end
        end else if (sts.srch_last) begin
          ctl.op = OP_MISS;
          state_nxt = S_RESP;
        end else begin
          ctl.op = OP_SSTEP;
        end
      end
      S_FIN2: begin
        ctl.op = OP_FIN2;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.op = OP_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ole_dp.sv -----
`default_nettype none
module ole_dp #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [31:0] in_value,
  input  wire logic               out_stall,
  input  wire ole_pkg::ctl_t      ctl,
  output ole_pkg::sts_t           sts,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_result_value,
  output logic [5:0]              out_position,
  output logic [6:0]              out_entry_count
);
  import ole_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]   vmem [DEPTH];
  logic [AW-1:0] lmem [DEPTH];
  logic [31:0]   vrd_r;
  logic [AW-1:0] lrd_r;

  logic          vwe, lwe;
  logic [AW-1:0] vwa, lwa, vra, lra, lwd;
  logic [31:0]   vwd;

  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt, free_r, free_nxt;
  logic [AW-1:0] cur_r, cur_nxt, prv_r, prv_nxt, pos_r, pos_nxt;
  logic [CW-1:0] count_r, count_nxt, idx_r, idx_nxt;
  logic [2:0]    cmd_r, cmd_nxt, st_r, st_nxt;
  logic [31:0]   val_r, val_nxt, rv_r, rv_nxt;
  logic          ov_r, ov_nxt;
  logic [2:0]    ost_r, ost_nxt;
  logic [31:0]   orv_r, orv_nxt;
  logic [5:0]    opos_r, opos_nxt;
  logic [6:0]    ocnt_r, ocnt_nxt;
  logic [31:0]   pos_ext, cnt_ext;
  logic [CW:0]   idx_p1, idx_p2;
  logic          modify;

  assign idx_p1  = {1'b0, idx_r} + 1'b1;
  assign idx_p2  = {1'b0, idx_r} + 2'd2;
  assign pos_ext = 32'(pos_r);
  assign cnt_ext = 32'(count_r);
  assign modify  = (cmd_r == CMD_RM_MATCH) || (cmd_r == CMD_MOVE && idx_r != '0);

  assign sts.empty     = (count_r == '0);
  assign sts.full      = (count_r == CW'(DEPTH));
  assign sts.cmd       = cmd_r;
  assign sts.match     = (vrd_r == val_r);
  assign sts.srch_last = (idx_p1 == {1'b0, count_r});
  assign sts.rmb_last  = (idx_p2 >= {1'b0, count_r});
  assign sts.at_first  = (idx_r == '0);
  assign sts.clr_last  = (idx_r == CW'(DEPTH - 1));
  assign sts.out_free  = !ov_r || !out_stall;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    free_nxt  = free_r;
    cur_nxt   = cur_r;
    prv_nxt   = prv_r;
    pos_nxt   = pos_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    cmd_nxt   = cmd_r;
    st_nxt    = st_r;
    val_nxt   = val_r;
    rv_nxt    = rv_r;
    ost_nxt   = ost_r;
    orv_nxt   = orv_r;
    opos_nxt  = opos_r;
    ocnt_nxt  = ocnt_r;
    ov_nxt    = ov_r && out_stall;
    vwe = 1'b0;
    lwe = 1'b0;
    vwa = cur_r;
    vwd = val_r;
    lwa = cur_r;
    lwd = free_r;
    case (ctl.op)
      OP_CLR: begin
        lwe = 1'b1;
        lwa = idx_r[AW-1:0];
        lwd = sts.clr_last ? '0 : AW'(idx_p1);
        idx_nxt = idx_p1[CW-1:0];
      end
      OP_START: begin
        cmd_nxt = in_command;
        val_nxt = in_value;
        rv_nxt  = '0;
        pos_nxt = '0;
        st_nxt  = ctl.st;
        cur_nxt = head_r;
        prv_nxt = head_r;
        idx_nxt = '0;
      end
      OP_INS: begin
        vwe = 1'b1;
        vwa = free_r;
        free_nxt = lrd_r;
        lwe = 1'b1;
        if (count_r == '0) begin
          lwa = free_r;
          lwd = free_r;
          head_nxt = free_r;
          tail_nxt = free_r;
        end else if (cmd_r == CMD_INS_FRONT) begin
          lwa = free_r;
          lwd = head_r;
          head_nxt = free_r;
        end else begin
          lwa = tail_r;
          lwd = free_r;
          tail_nxt = free_r;
        end
        count_nxt = count_r + 1'b1;
      end
      OP_RMF: begin
        rv_nxt = vrd_r;
        head_nxt = lrd_r;
        lwe = 1'b1;
        lwa = head_r;
        lwd = free_r;
        free_nxt = head_r;
        count_nxt = count_r - 1'b1;
      end
      OP_RMB_FIRST: begin
        rv_nxt = vrd_r;
      end
      OP_RMB_STEP: begin
        cur_nxt = lrd_r;
        idx_nxt = idx_p1[CW-1:0];
      end
      OP_RMB_END: begin
        tail_nxt = cur_r;
        lwe = 1'b1;
        lwa = tail_r;
        lwd = free_r;
        free_nxt = tail_r;
        pos_nxt = AW'(count_r - 1'b1);
        count_nxt = count_r - 1'b1;
      end
      OP_SSTEP: begin
        prv_nxt = cur_r;
        cur_nxt = lrd_r;
        idx_nxt = idx_p1[CW-1:0];
      end
      OP_MATCH: begin
        rv_nxt  = vrd_r;
        pos_nxt = idx_r[AW-1:0];
        st_nxt  = (cmd_r == CMD_MOVE && idx_r == '0) ? ST_FIRST : ST_OK;
        if (modify) begin
          if (idx_r == '0) begin
            head_nxt = lrd_r;
          end else begin
            lwe = 1'b1;
            lwa = prv_r;
            lwd = lrd_r;
            if (cur_r == tail_r) tail_nxt = prv_r;
          end
        end
      end
      OP_FIN2: begin
        lwe = 1'b1;
        lwa = cur_r;
        if (cmd_r == CMD_RM_MATCH) begin
          lwd = free_r;
          free_nxt = cur_r;
          count_nxt = count_r - 1'b1;
        end else begin
          lwd = head_r;
          head_nxt = cur_r;
        end
      end
      OP_MISS: begin
        st_nxt = ST_NOT_FOUND;
      end
      OP_LOAD: begin
        ov_nxt   = 1'b1;
        ost_nxt  = st_r;
        orv_nxt  = rv_r;
        opos_nxt = pos_ext[5:0];
        ocnt_nxt = cnt_ext[6:0];
      end
      default: begin
      end
    endcase
    lra = (ctl.op == OP_START &&
           (in_command == CMD_INS_FRONT || in_command == CMD_INS_BACK)) ? free_r : cur_nxt;
    vra = (ctl.op == OP_START && in_command == CMD_RM_BACK) ? tail_r : cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[vwa] <= vwd;
    vrd_r <= vmem[vra];
  end

  always_ff @(posedge clk) begin
    if (lwe) lmem[lwa] <= lwd;
    lrd_r <= lmem[lra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      free_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      free_r  <= free_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prv_r  <= prv_nxt;
    pos_r  <= pos_nxt;
    cmd_r  <= cmd_nxt;
    st_r   <= st_nxt;
    val_r  <= val_nxt;
    rv_r   <= rv_nxt;
    ost_r  <= ost_nxt;
    orv_r  <= orv_nxt;
    opos_r <= opos_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_result_value = orv_r;
  assign out_position     = opos_r;
  assign out_entry_count  = ocnt_r;

endmodule
`default_nettype wire

// ----- rtl/ordered_list_engine.sv -----
// Ordered list of up to DEPTH signed 32-bit values kept as a linked list.
// Input channel: in_valid/in_stall with in_command and in_value. A transfer
// happens on a rising edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall with out_status, out_result_value,
// out_position and out_entry_count; exactly one result per command.
// One command is worked at a time; the link walk reads the link memory
// once per cycle, so the time to a result grows with how far a command
// walks: remove back walks to the entry before the tail, a miss walks the
// whole list, find and remove/move match walk to the matching entry.
// Inserts, remove front and the empty, full and unused-command cases do
// not walk.
// in_stall drops at the same edge that raises out_valid.
// After reset the link memory is swept to rebuild the free list, with
// in_stall high throughout; the list then starts empty.
// A finished result waits in an output register while out_stall is high;
// the next command is taken meanwhile and its result waits until that
// register is free.
`default_nettype none
module ordered_list_engine #(
  parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_command,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_result_value,
  output logic [5:0]              out_position,
  output logic [6:0]              out_entry_count
);
  import ole_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ole_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .sts        (sts),
    .in_stall   (in_stall),
    .ctl        (ctl)
  );

  ole_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_value         (in_value),
    .out_stall        (out_stall),
    .ctl              (ctl),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_position     (out_position),
    .out_entry_count  (out_entry_count)
  );

endmodule
`default_nettype wire
